// File: hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Service codes, guard phases, and request and result types for the task scheduler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int unsigned TasksDef      = 32;
  localparam int unsigned WaitListsDef  = 8;
  localparam int unsigned GuardListsDef = 8;
  localparam int unsigned TimeWidthDef  = 32;

  typedef enum logic [3:0] {
    FN_SELECT    = 4'd0,
    FN_CREATE    = 4'd1,
    FN_TERMINATE = 4'd2,
    FN_BLOCKLIST = 4'd3,
    FN_BLOCKDL   = 4'd4,
    FN_BOTH      = 4'd5,
    FN_SIGNAL    = 4'd6,
    FN_TICK      = 4'd7,
    FN_ACCEPTED  = 4'd8,
    FN_GUARDCMD  = 4'd9,
    FN_GUARDWAIT = 4'd10,
    FN_WAITCHG   = 4'd11,
    FN_GUARDCHG  = 4'd12,
    FN_GUARDTICK = 4'd13
  } func_e;

  localparam logic [1:0] PhEval     = 2'd0;
  localparam logic [1:0] PhChanged  = 2'd1;
  localparam logic [1:0] PhWaiting  = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [4:0] woken_task;
    logic       return_code;
    logic       found;
    logic       running_valid;
    logic [4:0] running_task;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [4:0]  task_number;
    logic [2:0]  list_number;
    logic [2:0]  guard_number;
    logic [31:0] time_value;
  } req_t;

endpackage

// File: hdl/bts_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bts_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bts_ffs.sv
// ----------------------------------------------------------------------------
// Find first set
// Priority encoder shared by every scan of the scheduler.
// ----------------------------------------------------------------------------
module bts_ffs #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0]                          vec_i,
  output logic [((W > 1) ? $clog2(W) : 1)-1:0]  idx_o
);
  localparam int unsigned IW = (W > 1) ? $clog2(W) : 1;

  always_comb begin
    idx_o = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec_i[i]) idx_o = IW'(i);
    end
  end
endmodule

// File: hdl/bitmap_task_scheduler.sv
// ----------------------------------------------------------------------------
// Bitmap task scheduler
// Scheduler coprocessor: task bitmasks, wait lists, deadlines and guards.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one kernel service per transaction (func, task, list,
//   guard, time). res (source): zero or more woken-task reports followed
//   by one final status with last = 1.
//   Operation: a service is decoded in ST_EXEC, then the scan unit walks
//   the candidate mask with one shared find-first-set, one candidate per
//   cycle while the output register is free; the tick services first read
//   each candidate's deadline in ST_RDDL. Each result waits in the output
//   register until taken; the scan halts while it is full.
//   A new request is taken once the final status is in the output register.
//   Reset clears all masks, per-task state and the running task; the
//   deadline store is a memory that needs no clearing, since a deadline
//   is only read for tasks whose mask bit was set by a write.
//   A stalled receiver holds the current result and freezes the scan.
// ----------------------------------------------------------------------------
module bitmap_task_scheduler #(
  parameter int unsigned TASKS       = bts_pkg::TasksDef,
  parameter int unsigned WAIT_LISTS  = bts_pkg::WaitListsDef,
  parameter int unsigned GUARD_LISTS = bts_pkg::GuardListsDef,
  parameter int unsigned TIME_WIDTH  = bts_pkg::TimeWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  bts_if.sink   req,
  bts_if.source res
);
  import bts_pkg::*;

  localparam int unsigned TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned LW = (WAIT_LISTS > 1) ? $clog2(WAIT_LISTS) : 1;
  localparam int unsigned GW = (GUARD_LISTS > 1) ? $clog2(GUARD_LISTS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_RDDL = 5'b01000,
    ST_STAT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  req_t              cur_q;
  logic [TASKS-1:0]  ready_q, dlw_q, gdl_q, scan_q;
  logic [TASKS-1:0]  inl_q, dlg_q;
  logic [TASKS-1:0]  wl_q [WAIT_LISTS];
  logic [TASKS-1:0]  gl_q [GUARD_LISTS];
  logic [LW-1:0]     link_q [TASKS];
  logic [GUARD_LISTS-1:0] gset_q [TASKS];
  logic [1:0]        ph_q [TASKS];
  logic [TIME_WIDTH-1:0] dl_mem [TASKS];
  logic [TIME_WIDTH-1:0] dl_rd_q;
  logic              run_q;
  logic [4:0]        ridx_q;
  logic              found_q;
  logic              ov_q;
  res_t              ores_q;

  logic [TW-1:0]     ffs_idx;
  logic [TIME_WIDTH-1:0] tv;
  logic [TW-1:0]     r;
  logic [TW-1:0]     tn;
  logic [LW-1:0]     lidx;
  logic [GW-1:0]     gidx;
  logic              list_ok, guard_ok;
  logic              out_free;

  bts_ffs #(.W(TASKS)) u_ffs (.vec_i(scan_q), .idx_o(ffs_idx));

  assign tv       = TIME_WIDTH'(cur_q.time_value);
  assign r        = ridx_q[TW-1:0];
  assign tn       = cur_q.task_number[TW-1:0];
  assign lidx     = LW'(cur_q.list_number);
  assign gidx     = GW'(cur_q.guard_number);
  assign list_ok  = 32'(cur_q.list_number) < WAIT_LISTS;
  assign guard_ok = 32'(cur_q.guard_number) < GUARD_LISTS;
  assign out_free = !ov_q || res.ready;

  assign req.ready = (state_q == ST_IDLE);
  assign res.valid = ov_q;
  assign res.data  = ores_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && run_q && (cur_q.func == FN_BLOCKDL || cur_q.func == FN_BOTH)
        && list_ok | (cur_q.func == FN_BLOCKDL)) begin
      dl_mem[r] <= tv;
    end else if (state_q == ST_EXEC && run_q && cur_q.func == FN_GUARDWAIT
                 && ph_q[r] == PhEval && (!gdl_q[r] || dl_rd_q > tv)) begin
      dl_mem[r] <= tv;
    end else if (state_q == ST_EXEC && cur_q.func == FN_CREATE
                 && 32'(cur_q.task_number) < TASKS) begin
      dl_mem[tn] <= '0;
    end
    dl_rd_q <= dl_mem[(state_q == ST_IDLE) ? r : ffs_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= '0; dlw_q <= '0; gdl_q <= '0; scan_q <= '0;
      inl_q <= '0; dlg_q <= '0;
      run_q <= 1'b0; ridx_q <= '0; found_q <= 1'b0; ov_q <= 1'b0;
      ores_q <= '0; cur_q <= '0;
      for (int i = 0; i < WAIT_LISTS; i++) wl_q[i] <= '0;
      for (int i = 0; i < GUARD_LISTS; i++) gl_q[i] <= '0;
      for (int i = 0; i < TASKS; i++) begin
        link_q[i] <= '0; gset_q[i] <= '0; ph_q[i] <= PhEval;
      end
    end else begin
      if (res.ready) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (req.valid) begin
            cur_q   <= req.data;
            found_q <= 1'b0;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_STAT;
          case (cur_q.func)
            FN_SELECT: begin
              logic [TASKS-1:0] rm;
              rm = ready_q;
              if (run_q) rm[r] = 1'b1;
              run_q <= 1'b0;
              scan_q <= rm;
              ready_q <= rm;
              if (|rm) state_q <= ST_SCAN;
            end
            FN_CREATE: begin
              if (32'(cur_q.task_number) < TASKS) begin
                for (int i = 0; i < WAIT_LISTS; i++) wl_q[i][tn] <= 1'b0;
                for (int i = 0; i < GUARD_LISTS; i++) gl_q[i][tn] <= 1'b0;
                dlw_q[tn] <= 1'b0; gdl_q[tn] <= 1'b0;
                inl_q[tn] <= 1'b0; link_q[tn] <= '0; gset_q[tn] <= '0;
                ph_q[tn] <= PhEval; dlg_q[tn] <= 1'b0;
                if (run_q && ridx_q == cur_q.task_number) run_q <= 1'b0;
                ready_q[tn] <= 1'b1;
              end
            end
            FN_TERMINATE: run_q <= 1'b0;
            FN_BLOCKLIST, FN_BLOCKDL, FN_BOTH: begin
              if (run_q && (cur_q.func == FN_BLOCKDL || list_ok)) begin
                if (cur_q.func != FN_BLOCKDL) begin
                  wl_q[lidx][r] <= 1'b1;
                  inl_q[r] <= 1'b1; link_q[r] <= lidx;
                end
                if (cur_q.func != FN_BLOCKLIST) dlw_q[r] <= 1'b1;
                run_q <= 1'b0;
              end
            end
            FN_SIGNAL: begin
              if (list_ok) begin
                scan_q <= wl_q[lidx];
                if (|wl_q[lidx]) state_q <= ST_SCAN;
              end
            end
            FN_TICK: begin
              scan_q <= dlw_q;
              if (|dlw_q) state_q <= ST_RDDL;
            end
            FN_ACCEPTED: begin
              if (run_q) begin
                ph_q[r] <= PhEval;
                for (int g = 0; g < GUARD_LISTS; g++) gl_q[g][r] <= 1'b0;
                gset_q[r] <= '0; gdl_q[r] <= 1'b0; dlg_q[r] <= 1'b0;
              end
            end
            FN_GUARDCMD: begin
              if (run_q && guard_ok && ph_q[r] == PhEval) begin
                gl_q[gidx][r] <= 1'b1;
                gset_q[r][gidx] <= 1'b1;
              end
            end
            FN_GUARDWAIT: begin
              if (run_q && ph_q[r] == PhEval) begin
                dlg_q[r] <= 1'b1; gdl_q[r] <= 1'b1;
              end
            end
            FN_WAITCHG: begin
              if (run_q) begin
                if (ph_q[r] == PhChanged) begin
                  found_q <= 1'b1; ph_q[r] <= PhEval;
                end else if (dlg_q[r] || |gset_q[r]) begin
                  found_q <= 1'b1; ph_q[r] <= PhWaiting; run_q <= 1'b0;
                end
              end
            end
            FN_GUARDCHG: begin
              if (guard_ok) begin
                scan_q <= gl_q[gidx];
                if (|gl_q[gidx]) state_q <= ST_SCAN;
              end
            end
            FN_GUARDTICK: begin
              scan_q <= gdl_q;
              if (|gdl_q) state_q <= ST_RDDL;
            end
            default: ;
          endcase
        end
        ST_RDDL: state_q <= ST_SCAN;
        ST_SCAN: begin
          if (out_free) begin
            logic [TASKS-1:0] rest;
            logic             hit;
            rest = scan_q;
            rest[ffs_idx] = 1'b0;
            hit  = 1'b0;
            case (cur_q.func)
              FN_SELECT: begin
                ready_q[ffs_idx] <= 1'b0;
                run_q <= 1'b1; ridx_q <= 5'(ffs_idx);
                rest = '0;
              end
              FN_SIGNAL: begin
                found_q <= 1'b1;
                dlw_q[ffs_idx] <= 1'b0;
                wl_q[lidx][ffs_idx] <= 1'b0;
                inl_q[ffs_idx] <= 1'b0;
                ready_q[ffs_idx] <= 1'b1;
                hit = 1'b1;
                ores_q <= '{kind: 1'b0, woken_task: 5'(ffs_idx), return_code: 1'b1,
                            default: '0};
                rest = '0;
              end
              FN_TICK: begin
                if (tv >= dl_rd_q) begin
                  dlw_q[ffs_idx] <= 1'b0;
                  if (inl_q[ffs_idx]) begin
                    wl_q[link_q[ffs_idx]][ffs_idx] <= 1'b0;
                    inl_q[ffs_idx] <= 1'b0;
                  end
                  ready_q[ffs_idx] <= 1'b1;
                  hit = 1'b1;
                  ores_q <= '{kind: 1'b0, woken_task: 5'(ffs_idx), default: '0};
                end
              end
              default: begin
                if (cur_q.func == FN_GUARDCHG || tv >= dl_rd_q) begin
                  // guard list membership always mirrors the task's guard set
                  for (int g = 0; g < GUARD_LISTS; g++)
                    if (gset_q[ffs_idx][g]) gl_q[g][ffs_idx] <= 1'b0;
                  gset_q[ffs_idx] <= '0; gdl_q[ffs_idx] <= 1'b0; dlg_q[ffs_idx] <= 1'b0;
                  if (ph_q[ffs_idx] == PhWaiting) begin
                    ph_q[ffs_idx] <= PhEval;
                    ready_q[ffs_idx] <= 1'b1;
                    hit = 1'b1;
                    ores_q <= '{kind: 1'b0, woken_task: 5'(ffs_idx), return_code: 1'b1,
                                default: '0};
                  end else if (ph_q[ffs_idx] == PhEval) begin
                    ph_q[ffs_idx] <= PhChanged;
                  end
                end
              end
            endcase
            if (hit) ov_q <= 1'b1;
            scan_q <= rest;
            if (!(|rest)) state_q <= ST_STAT;
            else if (cur_q.func == FN_TICK || cur_q.func == FN_GUARDTICK) state_q <= ST_RDDL;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            ores_q <= '{kind: 1'b1, found: found_q, running_valid: run_q,
                        running_task: run_q ? ridx_q : 5'd0, last: 1'b1, default: '0};
            ov_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/bts_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level properties of the scheduler, bound into the scheduler module.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input bts_pkg::res_t res_data_i
);
  import bts_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result dropped while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.kind == res_data_i.last))
    else $error("last does not match kind");

  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_data_i.kind |-> !res_data_i.running_valid && !res_data_i.found)
    else $error("report carries status fields");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready during service");
endmodule

bind bitmap_task_scheduler bts_checker u_bts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid_i(req.valid), .req_ready_i(req.ready),
  .res_valid_i(res.valid), .res_ready_i(res.ready), .res_data_i(res.data)
);
